@@ design/lzss_stream_decompressor_assert.svh @@
`ifndef LZSS_STREAM_DECOMPRESSOR_ASSERT_SVH
`define LZSS_STREAM_DECOMPRESSOR_ASSERT_SVH

// cond must hold on every clock edge out of reset
`define LZSS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// ante in one cycle implies cons in the same cycle
`define LZSS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// ante in one cycle implies cons in the following cycle
`define LZSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lzss_pkg.sv @@
package lzss_pkg;

    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int FILL_W       = WIN_AW + 1;

    localparam logic [WIN_AW-1:0] WIN_INIT  = WIN_AW'(12'hfee);
    localparam logic [7:0]        FILL_BYTE = 8'h20;
    localparam int                LEN_BIAS  = 3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic REG_COMPRESSED_LENGTH = 1'b0;

    typedef struct packed {
        logic              en;
        logic [WIN_AW-1:0] addr;
        logic [7:0]        data;
    } win_wr_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_done;
    } out_item_t;

endpackage

@@ design/lzss_window_ram.sv @@
module lzss_window_ram (
    input  logic                      aclk,
    input  lzss_pkg::win_wr_t         wr,
    input  logic                      rd_en,
    input  logic [lzss_pkg::WIN_AW-1:0] rd_addr,
    output logic [7:0]                rd_data
);
    import lzss_pkg::*;

    logic [7:0] mem [WINDOW_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/lzss_out_fifo.sv @@
module lzss_out_fifo (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  lzss_pkg::out_item_t          push_item,
    output logic [lzss_pkg::FIFO_CW-1:0] count,
    output logic                         m_valid,
    input  logic                         m_ready,
    output lzss_pkg::out_item_t          m_item
);
    import lzss_pkg::*;

    out_item_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] cnt_reg;
    logic [FIFO_CW-1:0] cnt_next;
    logic               pop;

    assign m_valid = (cnt_reg != '0);
    assign pop     = m_valid && m_ready;
    assign m_item  = mem[rd_ptr_reg];
    assign count   = cnt_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + FIFO_CW'(1);
        end else if (!push && pop) begin
            cnt_next = cnt_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
        end
    end

endmodule

@@ design/lzss_ctrl.sv @@
module lzss_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_in_byte,
    input  logic                           s_stream_start,
    input  logic [15:0]                    cfg_length,
    input  logic [lzss_pkg::FIFO_CW-1:0]   fifo_cnt,
    output lzss_pkg::win_wr_t              wr,
    output logic                           rd_en,
    output logic [lzss_pkg::WIN_AW-1:0]    rd_addr,
    input  logic [7:0]                     ram_rdata,
    output logic                           push,
    output lzss_pkg::out_item_t            push_item
);
    import lzss_pkg::*;

    typedef enum logic [1:0] {PH_CTRL, PH_ITEM, PH_PAIR_HI} phase_t;
    typedef enum logic {ST_IDLE, ST_COPY} state_t;

    localparam logic [3:0] FLAGS_PER_CTRL = 4'd8;

    state_t             st_reg, st_next;
    phase_t             phase_reg, phase_next;
    logic [7:0]         flag_reg, flag_next;
    logic [3:0]         fleft_reg, fleft_next;
    logic [7:0]         low_reg, low_next;
    logic [15:0]        cnt_reg, cnt_next;
    logic               fin_reg, fin_next;
    logic [WIN_AW-1:0]  wpos_reg, wpos_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [WIN_AW-1:0]  src_reg, src_next;
    logic [4:0]         left_reg, left_next;
    logic               done_reg, done_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rd_last_reg, rd_last_next;
    logic               rd_fwd_reg, rd_fwd_next;
    logic               rd_hit_reg, rd_hit_next;
    logic [7:0]         fwd_data_reg, fwd_data_next;

    logic               accept;
    logic               issue;
    logic [7:0]         rd_data;
    phase_t             eff_phase;
    logic [7:0]         eff_flag;
    logic [3:0]         eff_fleft;
    logic [15:0]        eff_cnt;
    logic               eff_fin;
    logic [15:0]        cnt_inc;
    logic               done_new;
    logic [3:0]         fleft_dec;
    logic [WIN_AW-1:0]  win_off;
    logic [FIFO_CW:0]   credit_use;

    assign s_ready = (st_reg == ST_IDLE) && !rd_pend_reg &&
                     (fifo_cnt < FIFO_CW'(FIFO_DEPTH));
    assign accept  = s_valid && s_ready;

    // forwarded byte wins over the array when the read hit the entry being written
    assign rd_data = rd_fwd_reg ? fwd_data_reg : (rd_hit_reg ? ram_rdata : FILL_BYTE);

    // a stream start reinitialises before the byte is looked at
    assign eff_phase = s_stream_start ? PH_CTRL : phase_reg;
    assign eff_flag  = s_stream_start ? 8'h00 : flag_reg;
    assign eff_fleft = s_stream_start ? 4'h0 : fleft_reg;
    assign eff_cnt   = s_stream_start ? 16'h0000 : cnt_reg;
    assign eff_fin   = s_stream_start ? 1'b0 : fin_reg;

    assign cnt_inc   = (eff_cnt == 16'hffff) ? eff_cnt : eff_cnt + 16'd1;
    assign done_new  = (cnt_inc >= cfg_length);
    assign fleft_dec = (eff_fleft == 4'h0) ? 4'h0 : eff_fleft - 4'd1;

    assign credit_use = {1'b0, fifo_cnt} + {{FIFO_CW{1'b0}}, rd_pend_reg};
    assign issue      = (st_reg == ST_COPY) && (credit_use < (FIFO_CW+1)'(FIFO_DEPTH));

    // entries not yet written since the stream began read as fill bytes
    assign win_off = src_reg - WIN_INIT;

    always_comb begin
        st_next       = st_reg;
        phase_next    = phase_reg;
        flag_next     = flag_reg;
        fleft_next    = fleft_reg;
        low_next      = low_reg;
        cnt_next      = cnt_reg;
        fin_next      = fin_reg;
        wpos_next     = wpos_reg;
        fill_next     = fill_reg;
        src_next      = src_reg;
        left_next     = left_reg;
        done_next     = done_reg;
        rd_last_next  = rd_last_reg;
        rd_fwd_next   = 1'b0;
        rd_hit_next   = rd_hit_reg;
        fwd_data_next = fwd_data_reg;
        wr            = '0;
        push          = 1'b0;
        push_item     = '0;
        rd_en         = 1'b0;
        rd_addr       = src_reg;

        if (rd_pend_reg) begin
            wr.en     = 1'b1;
            wr.addr   = wpos_reg;
            wr.data   = rd_data;
            push      = 1'b1;
            push_item = '{out_byte: rd_data, last_of_run: rd_last_reg, stream_done: done_reg};
        end

        if (accept) begin
            if (s_stream_start) begin
                phase_next = PH_CTRL;
                flag_next  = 8'h00;
                fleft_next = 4'h0;
                low_next   = 8'h00;
                cnt_next   = 16'h0000;
                fin_next   = 1'b0;
                wpos_next  = WIN_INIT;
                fill_next  = '0;
            end
            priority if (eff_fin) begin
                // stream over: byte dropped
            end else if ((eff_phase != PH_PAIR_HI) && (eff_cnt >= cfg_length)) begin
                fin_next = 1'b1;
            end else begin
                cnt_next = cnt_inc;
                unique case (eff_phase)
                    PH_CTRL: begin
                        flag_next  = s_in_byte;
                        fleft_next = FLAGS_PER_CTRL;
                        phase_next = PH_ITEM;
                        if (done_new) fin_next = 1'b1;
                    end
                    PH_ITEM: begin
                        if (eff_flag[0]) begin
                            wr.en      = 1'b1;
                            wr.addr    = wpos_reg;
                            wr.data    = s_in_byte;
                            push       = 1'b1;
                            push_item  = '{out_byte: s_in_byte, last_of_run: 1'b1,
                                          stream_done: done_new};
                            flag_next  = {1'b0, eff_flag[7:1]};
                            fleft_next = fleft_dec;
                            phase_next = (fleft_dec == 4'h0) ? PH_CTRL : PH_ITEM;
                            if (done_new) fin_next = 1'b1;
                        end else begin
                            low_next   = s_in_byte;
                            phase_next = PH_PAIR_HI;
                        end
                    end
                    PH_PAIR_HI: begin
                        src_next   = {s_in_byte[7:4], low_reg};
                        left_next  = {1'b0, s_in_byte[3:0]} + 5'(LEN_BIAS);
                        done_next  = done_new;
                        st_next    = ST_COPY;
                        flag_next  = {1'b0, eff_flag[7:1]};
                        fleft_next = fleft_dec;
                        phase_next = (fleft_dec == 4'h0) ? PH_CTRL : PH_ITEM;
                        if (done_new) fin_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (wr.en) begin
            wpos_next = wr.addr + WIN_AW'(1);
            if (fill_reg != FILL_W'(WINDOW_DEPTH)) begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end

        if (issue) begin
            rd_en         = 1'b1;
            rd_hit_next   = ({1'b0, win_off} < fill_reg);
            rd_fwd_next   = wr.en && (wr.addr == src_reg);
            fwd_data_next = wr.data;
            rd_last_next  = (left_reg == 5'd1);
            src_next      = src_reg + WIN_AW'(1);
            left_next     = left_reg - 5'd1;
            if (left_reg == 5'd1) st_next = ST_IDLE;
        end
        rd_pend_next = issue;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            phase_reg   <= PH_CTRL;
            flag_reg    <= 8'h00;
            fleft_reg   <= 4'h0;
            low_reg     <= 8'h00;
            cnt_reg     <= 16'h0000;
            fin_reg     <= 1'b0;
            wpos_reg    <= WIN_INIT;
            fill_reg    <= '0;
            rd_pend_reg <= 1'b0;
            rd_fwd_reg  <= 1'b0;
        end else begin
            st_reg      <= st_next;
            phase_reg   <= phase_next;
            flag_reg    <= flag_next;
            fleft_reg   <= fleft_next;
            low_reg     <= low_next;
            cnt_reg     <= cnt_next;
            fin_reg     <= fin_next;
            wpos_reg    <= wpos_next;
            fill_reg    <= fill_next;
            rd_pend_reg <= rd_pend_next;
            rd_fwd_reg  <= rd_fwd_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg      <= src_next;
        left_reg     <= left_next;
        done_reg     <= done_next;
        rd_last_reg  <= rd_last_next;
        rd_hit_reg   <= rd_hit_next;
        fwd_data_reg <= fwd_data_next;
    end

endmodule

@@ design/lzss_stream_decompressor.sv @@
// Control, literal and pair low bytes are taken one per cycle while the queue has room. A pair's
// second byte holds the input for its copy of 3..18 bytes, set by the single window read port: one
// byte read, forwarded and written back per cycle while the queue has room, the first result
// passing the state register, read register and queue, then one per cycle while m_ready is high.
// aresetn (synchronous, active low) clears control state; the window is not swept, since a fill
// count marks entries unwritten since the stream began and those read as 0x20, so start is instant.
module lzss_stream_decompressor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_stream_start,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last_of_run,
    output logic        m_stream_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lzss_pkg::*;

    `include "lzss_stream_decompressor_assert.svh"

    logic [15:0]        length_reg;
    logic               cfg_wr;
    win_wr_t            wr;
    logic               rd_en;
    logic [WIN_AW-1:0]  rd_addr;
    logic [7:0]         ram_rdata;
    logic               push;
    out_item_t          push_item;
    out_item_t          m_item;
    logic [FIFO_CW-1:0] fifo_cnt;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_COMPRESSED_LENGTH) ? {16'h0000, length_reg} : 32'h0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= 16'h0000;
        end else if (cfg_wr && (paddr[2] == REG_COMPRESSED_LENGTH)) begin
            length_reg <= pwdata[15:0];
        end
    end

    lzss_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_stream_start (s_stream_start),
        .cfg_length     (length_reg),
        .fifo_cnt       (fifo_cnt),
        .wr             (wr),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .ram_rdata      (ram_rdata),
        .push           (push),
        .push_item      (push_item)
    );

    lzss_window_ram u_window (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    lzss_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .count     (fifo_cnt),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    assign m_out_byte    = m_item.out_byte;
    assign m_last_of_run = m_item.last_of_run;
    assign m_stream_done = m_item.stream_done;

    // credit scheme must never overrun the result queue
    `LZSS_ASSERT_IMPLIES(a_no_overrun, push, (fifo_cnt < FIFO_CW'(FIFO_DEPTH)) || (m_valid && m_ready), "result queue overrun")
    // every window read returns and is written back the next cycle
    `LZSS_ASSERT_NEXT(a_read_writes_back, rd_en, wr.en && push, "copy read not written back")
    // a new stream never starts while a copied byte is still being written
    `LZSS_ASSERT_IMPLIES(a_start_quiet, s_valid && s_ready && s_stream_start, !wr.en, "stream start during window write")
    // no input transaction while a copy read is outstanding
    `LZSS_ASSERT_ALWAYS(a_ready_excl, !(s_ready && rd_en), "input taken during copy")

endmodule
